// File: hw/rtl/slet_pkg.sv
// Shared types, character codes and the byte classifier of the shell line editor.
// Used by slet_ctrl, slet_dpath and the top level shell_line_editor_tokenizer.
`timescale 1ns / 1ps

package slet_pkg;

    localparam int LINE_DEPTH_DEF = 32;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_TOKEN = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_ERASE = 2'd1,
        CLS_ENTER = 2'd2,
        CLS_PRINT = 2'd3
    } class_t;

    typedef enum logic [1:0] {
        SRC_CONST = 2'd0,
        SRC_RX    = 2'd1,
        SRC_PREV  = 2'd2
    } src_t;

    typedef enum logic [1:0] {
        WEND_ZERO = 2'd0,
        WEND_ONE  = 2'd1,
        WEND_NEXT = 2'd2
    } wend_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ECHO_PUT,
        ST_BS1,
        ST_BS2,
        ST_BS3,
        ST_CR,
        ST_LF,
        ST_SCAN_RD,
        ST_SCAN_DATA,
        ST_FLUSH,
        ST_LINE_END
    } state_t;

    typedef struct packed {
        logic       load_rx;
        logic       buf_wr;
        logic       fill_inc;
        logic       fill_dec;
        logic       fill_clr;
        logic       scan_clr;
        logic       rd_en;
        logic       scan_adv;
        logic       out_load;
        kind_t      out_kind;
        src_t       out_src;
        logic [7:0] out_const;
        wend_t      wend_sel;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        class_t byte_class;
        logic   fill_zero;
        logic   fill_full;
        logic   echo_en;
        logic   scan_done;
        logic   prev_valid;
        logic   out_free;
    } status_t;

    function automatic class_t classify(input logic [7:0] b);
        class_t c;
        c = CLS_OTHER;
        if (b == CH_BS || b == CH_DEL) begin
            c = CLS_ERASE;
        end else if (b == CH_CR || b == CH_LF) begin
            c = CLS_ENTER;
        end else if (b >= CH_SPACE && b <= CH_TILDE) begin
            c = CLS_PRINT;
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/shell_line_editor_tokenizer.sv
// Top level of the serial terminal line editor with word splitting.
// Depends on slet_pkg, slet_ctrl, slet_dpath and slet_ram.
//
// Usage: received terminal bytes enter on the s_ channel, one byte per transaction.
// Results leave on the m_ channel: m_tuser is the item kind (echo, token character,
// line end), m_tdata carries the byte and the word-end flag, and m_tlast marks the
// final result caused by one received byte. cfg_wr_en/cfg_wr_data set the echo
// enable; write it only while the block is idle.
// Throughput: one byte is handled at a time; s_tready is high only between bytes.
// A byte with no result, or a printable byte with echo off, needs only ST_IDLE.
// A printable byte with echo goes on to ST_ECHO_PUT, which loads its echo into the
// output register; a backspace with echo goes through ST_BS1, ST_BS2 and ST_BS3.
// An Enter reads the line buffer RAM one entry at a time through its single
// registered read port in ST_SCAN_RD and ST_SCAN_DATA, then ends in ST_FLUSH and
// ST_LINE_END; with echo, ST_CR and ST_LF come first. The receiver can stall it.
// A single output register sits on the m_ side; while it is held by m_tready low,
// the sequencer waits and no new byte is taken once the current byte needs it.
// Reset clears the fill count, echo enable, state and output valid at once;
// there is no clearing pass over the buffer.
`timescale 1ns / 1ps

module shell_line_editor_tokenizer #(
    parameter int LINE_DEPTH = slet_pkg::LINE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // echo_enable
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // [7:0] out_byte, [8] word_end, [15:9] zero
    output logic [1:0]  m_tuser,       // [1:0] item_kind
    output logic        m_tlast        // last_of_run
);

    slet_pkg::cmd_t    cmd;
    slet_pkg::status_t status;

    slet_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    slet_dpath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .rx_byte     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// File: hw/rtl/slet_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the line buffer; no dependencies.
`timescale 1ns / 1ps

module slet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/slet_dpath.sv
// Datapath of the line editor: line buffer, fill count, scan pointer and output register.
// Depends on slet_pkg and slet_ram; driven by commands from slet_ctrl.
`timescale 1ns / 1ps

module slet_dpath #(
    parameter int LINE_DEPTH = slet_pkg::LINE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  slet_pkg::cmd_t    cmd,
    output slet_pkg::status_t status,
    input  logic [7:0]        rx_byte,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic                  echo_reg;
    logic [CW-1:0]         fill_reg, fill_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  have_prev_reg, have_prev_next;
    logic [7:0]            prev_reg;
    logic [7:0]            rx_hold_reg;
    logic [7:0]            rd_data;
    logic [CW-1:0]         wr_pos;

    logic                  out_valid_reg, out_valid_next;
    slet_pkg::kind_t       out_kind_reg;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  out_wend_reg, out_wend_next;
    logic                  out_last_reg;

    assign wr_pos = fill_reg;

    slet_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.buf_wr),
        .wr_addr (wr_pos[AW-1:0]),
        .wr_data (rx_byte),
        .rd_en   (cmd.rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        fill_next = fill_reg;
        if (cmd.fill_clr) begin
            fill_next = '0;
        end else if (cmd.fill_inc) begin
            fill_next = fill_reg + CW'(1);
        end else if (cmd.fill_dec) begin
            fill_next = fill_reg - CW'(1);
        end

        idx_next       = idx_reg;
        have_prev_next = have_prev_reg;
        if (cmd.scan_clr) begin
            idx_next       = '0;
            have_prev_next = 1'b0;
        end else if (cmd.scan_adv) begin
            idx_next       = idx_reg + CW'(1);
            have_prev_next = 1'b1;
        end
    end

    always_comb begin
        unique case (cmd.out_src)
            slet_pkg::SRC_RX:   out_byte_next = rx_hold_reg;
            slet_pkg::SRC_PREV: out_byte_next = prev_reg;
            default:            out_byte_next = cmd.out_const;
        endcase
        unique case (cmd.wend_sel)
            slet_pkg::WEND_ONE:  out_wend_next = 1'b1;
            slet_pkg::WEND_NEXT: out_wend_next = (rd_data == slet_pkg::CH_SPACE);
            default:             out_wend_next = 1'b0;
        endcase
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_reg      <= 1'b0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                echo_reg <= cfg_wr_data;
            end
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            have_prev_reg <= have_prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_rx) begin
            rx_hold_reg <= rx_byte;
        end
        if (cmd.scan_adv) begin
            prev_reg <= rd_data;
        end
        if (cmd.out_load) begin
            out_kind_reg <= cmd.out_kind;
            out_byte_reg <= out_byte_next;
            out_wend_reg <= out_wend_next;
            out_last_reg <= cmd.out_last;
        end
    end

    always_comb begin
        status.byte_class = slet_pkg::classify(rx_byte);
        status.fill_zero  = (fill_reg == '0);
        status.fill_full  = (fill_reg == CW'(LINE_DEPTH));
        status.echo_en    = echo_reg;
        status.scan_done  = (idx_reg == fill_reg);
        status.prev_valid = have_prev_reg && (prev_reg != slet_pkg::CH_SPACE);
        status.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_wend_reg, out_byte_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hw/rtl/slet_ctrl.sv
// Controller of the line editor: decodes each received byte and sequences echo,
// buffer scan and line-end results. Depends on slet_pkg; drives slet_dpath.
`timescale 1ns / 1ps

module slet_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  slet_pkg::status_t status,
    output slet_pkg::cmd_t    cmd
);

    slet_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= slet_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.out_kind  = slet_pkg::KIND_ECHO;
        cmd.out_src   = slet_pkg::SRC_CONST;
        cmd.out_const = slet_pkg::CH_NUL;
        cmd.wend_sel  = slet_pkg::WEND_ZERO;

        unique case (state_reg)
            slet_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (status.byte_class)
                        slet_pkg::CLS_ERASE: begin
                            if (!status.fill_zero) begin
                                cmd.fill_dec = 1'b1;
                                if (status.echo_en) begin
                                    state_next = slet_pkg::ST_BS1;
                                end
                            end
                        end
                        slet_pkg::CLS_ENTER: begin
                            cmd.scan_clr = 1'b1;
                            state_next   = status.echo_en ? slet_pkg::ST_CR
                                                          : slet_pkg::ST_SCAN_RD;
                        end
                        slet_pkg::CLS_PRINT: begin
                            if (!status.fill_full) begin
                                cmd.buf_wr   = 1'b1;
                                cmd.fill_inc = 1'b1;
                                cmd.load_rx  = 1'b1;
                                if (status.echo_en) begin
                                    state_next = slet_pkg::ST_ECHO_PUT;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            slet_pkg::ST_ECHO_PUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = slet_pkg::SRC_RX;
                    cmd.out_last = 1'b1;
                    state_next   = slet_pkg::ST_IDLE;
                end
            end
            slet_pkg::ST_BS1: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_const = slet_pkg::CH_BS;
                    state_next    = slet_pkg::ST_BS2;
                end
            end
            slet_pkg::ST_BS2: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_const = slet_pkg::CH_SPACE;
                    state_next    = slet_pkg::ST_BS3;
                end
            end
            slet_pkg::ST_BS3: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_const = slet_pkg::CH_BS;
                    cmd.out_last  = 1'b1;
                    state_next    = slet_pkg::ST_IDLE;
                end
            end
            slet_pkg::ST_CR: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_const = slet_pkg::CH_CR;
                    state_next    = slet_pkg::ST_LF;
                end
            end
            slet_pkg::ST_LF: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_const = slet_pkg::CH_LF;
                    state_next    = slet_pkg::ST_SCAN_RD;
                end
            end
            slet_pkg::ST_SCAN_RD: begin
                if (status.scan_done) begin
                    state_next = slet_pkg::ST_FLUSH;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = slet_pkg::ST_SCAN_DATA;
                end
            end
            slet_pkg::ST_SCAN_DATA: begin
                // The held character goes out once its successor is known, so the
                // successor decides whether it closes a word.
                if (!status.prev_valid || status.out_free) begin
                    cmd.out_load = status.prev_valid;
                    cmd.out_kind = slet_pkg::KIND_TOKEN;
                    cmd.out_src  = slet_pkg::SRC_PREV;
                    cmd.wend_sel = slet_pkg::WEND_NEXT;
                    cmd.scan_adv = 1'b1;
                    state_next   = slet_pkg::ST_SCAN_RD;
                end
            end
            slet_pkg::ST_FLUSH: begin
                if (!status.prev_valid || status.out_free) begin
                    cmd.out_load = status.prev_valid;
                    cmd.out_kind = slet_pkg::KIND_TOKEN;
                    cmd.out_src  = slet_pkg::SRC_PREV;
                    cmd.wend_sel = slet_pkg::WEND_ONE;
                    state_next   = slet_pkg::ST_LINE_END;
                end
            end
            slet_pkg::ST_LINE_END: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = slet_pkg::KIND_END;
                    cmd.out_last = 1'b1;
                    cmd.fill_clr = 1'b1;
                    state_next   = slet_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = slet_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: tb/tb.sv
// Self-checking testbench for shell_line_editor_tokenizer: directed table, then random lines.
// Depends on slet_pkg and the RTL of the line editor; results are checked against a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int LINE_DEPTH  = slet_pkg::LINE_DEPTH_DEF;
    localparam int SETTLE      = 12;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_ITEMS = 90;

    typedef struct packed {
        slet_pkg::kind_t kind;
        logic [7:0]      ch;
        logic            wend;
        logic            last;
    } term_item_t;

    typedef struct {
        bit         echo;
        logic [7:0] rx;
        int         reps;
        bit         typed;
        bit         typed_has;
        term_item_t typed_item;
    } dir_row_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Predictor state: the line as the block should hold it.
    logic [7:0]  line_buf [LINE_DEPTH];
    logic [5:0]  line_fill = '0;
    logic        echo_on   = 1'b0;

    term_item_t  results_due [$];
    dir_row_t    dir_rows [$];
    term_item_t  want_item;
    int          errors = 0;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_toggle = 1'b0;
    logic        hold_seen   = 1'b0;
    int unsigned hold_left   = 0;

    shell_line_editor_tokenizer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),      // [7:0] rx_byte
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),      // [7:0] out_byte, [8] word_end, [15:9] zero
        .m_tuser     (m_tuser),      // [1:0] item_kind
        .m_tlast     (m_tlast)       // last_of_run
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic term_item_t term_item(input slet_pkg::kind_t kind,
                                             input logic [7:0] ch,
                                             input logic wend, input logic last);
        term_item_t it;
        it.kind = kind;
        it.ch   = ch;
        it.wend = wend;
        it.last = last;
        return it;
    endfunction

    // Updates the line state for one received byte and, if asked, queues its results.
    task automatic edit_line(input logic [7:0] b, input bit keep);
        term_item_t run [$];
        term_item_t last_item;
        logic       wend;
        int         fill;
        fill = line_fill;
        if (b == slet_pkg::CH_BS || b == slet_pkg::CH_DEL) begin
            if (fill > 0) begin
                if (echo_on) begin
                    run.insert(run.size(), term_item(slet_pkg::KIND_ECHO, slet_pkg::CH_BS,
                                                     1'b0, 1'b0));
                    run.insert(run.size(), term_item(slet_pkg::KIND_ECHO, slet_pkg::CH_SPACE,
                                                     1'b0, 1'b0));
                    run.insert(run.size(), term_item(slet_pkg::KIND_ECHO, slet_pkg::CH_BS,
                                                     1'b0, 1'b0));
                end
                line_fill = line_fill - 6'd1;
            end
        end else if (b == slet_pkg::CH_CR || b == slet_pkg::CH_LF) begin
            if (echo_on) begin
                run.insert(run.size(), term_item(slet_pkg::KIND_ECHO, slet_pkg::CH_CR,
                                                 1'b0, 1'b0));
                run.insert(run.size(), term_item(slet_pkg::KIND_ECHO, slet_pkg::CH_LF,
                                                 1'b0, 1'b0));
            end
            for (int i = 0; i < fill; i++) begin
                if (line_buf[i] != slet_pkg::CH_SPACE) begin
                    wend = (i + 1 >= fill) || (line_buf[i + 1] == slet_pkg::CH_SPACE);
                    run.insert(run.size(), term_item(slet_pkg::KIND_TOKEN, line_buf[i],
                                                     wend, 1'b0));
                end
            end
            line_fill = '0;
            run.insert(run.size(), term_item(slet_pkg::KIND_END, slet_pkg::CH_NUL,
                                             1'b0, 1'b0));
        end else if (b >= slet_pkg::CH_SPACE && b <= slet_pkg::CH_TILDE) begin
            // A full line drops the byte without any echo.
            if (fill < LINE_DEPTH) begin
                line_buf[fill] = b;
                line_fill = line_fill + 6'd1;
                if (echo_on) begin
                    run.insert(run.size(), term_item(slet_pkg::KIND_ECHO, b, 1'b0, 1'b0));
                end
            end
        end
        if (run.size() > 0) begin
            last_item = run[run.size() - 1];
            last_item.last = 1'b1;
            run[run.size() - 1] = last_item;
        end
        if (keep) begin
            foreach (run[i]) begin
                results_due.insert(results_due.size(), run[i]);
            end
        end
    endtask

    // Offers one byte and returns at the edge where the transaction completes.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic feed_byte(input logic [7:0] b);
        send_byte(b);
        edit_line(b, 1'b1);
    endtask

    task automatic set_echo(input logic value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        echo_on = value;
    endtask

    task automatic add_row(input bit echo, input logic [7:0] rx, input int reps,
                           input bit typed, input bit has, input term_item_t item);
        dir_row_t row;
        row.echo       = echo;
        row.rx         = rx;
        row.reps       = reps;
        row.typed      = typed;
        row.typed_has  = has;
        row.typed_item = item;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_seen <= hold_toggle;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual kind %0d byte 0x%h",
                         $time, m_tuser, m_tdata[7:0]);
            end else begin
                want_item = results_due.pop_front();
                check_field("item_kind", want_item.kind, m_tuser);
                check_field("out_byte", want_item.ch, m_tdata[7:0]);
                check_field("word_end", want_item.wend, m_tdata[8]);
                check_field("last_of_run", want_item.last, m_tlast);
                check_field("tdata padding", 0, m_tdata[15:9]);
            end
        end
    end

    initial begin
        int         line_len;
        int         pick;
        int         line_bytes;
        logic [7:0] b;

        // Echo off: reset state, ignored bytes, then a short line split into words.
        add_row(1'b0, slet_pkg::CH_CR,    1, 1'b1, 1'b1,
                term_item(slet_pkg::KIND_END, slet_pkg::CH_NUL, 1'b0, 1'b1));
        add_row(1'b0, slet_pkg::CH_BS,    1, 1'b1, 1'b0, '0);
        add_row(1'b0, slet_pkg::CH_DEL,   1, 1'b1, 1'b0, '0);
        add_row(1'b0, 8'h00,              1, 1'b1, 1'b0, '0);
        add_row(1'b0, 8'hFF,              1, 1'b1, 1'b0, '0);
        add_row(1'b0, 8'h80,              1, 1'b1, 1'b0, '0);
        add_row(1'b0, 8'h1F,              1, 1'b1, 1'b0, '0);
        add_row(1'b0, slet_pkg::CH_SPACE, 1, 1'b0, 1'b0, '0);
        add_row(1'b0, slet_pkg::CH_TILDE, 1, 1'b0, 1'b0, '0);
        add_row(1'b0, 8'h41,              1, 1'b0, 1'b0, '0);
        add_row(1'b0, slet_pkg::CH_SPACE, 1, 1'b0, 1'b0, '0);
        add_row(1'b0, 8'h21,              1, 1'b0, 1'b0, '0);
        add_row(1'b0, slet_pkg::CH_LF,    1, 1'b0, 1'b0, '0);
        // Echo on: erase on an empty line, an all-space line, then a full line.
        add_row(1'b1, slet_pkg::CH_DEL,   1, 1'b1, 1'b0, '0);
        add_row(1'b1, slet_pkg::CH_SPACE, 1, 1'b1, 1'b1,
                term_item(slet_pkg::KIND_ECHO, slet_pkg::CH_SPACE, 1'b0, 1'b1));
        add_row(1'b1, slet_pkg::CH_TILDE, 1, 1'b1, 1'b1,
                term_item(slet_pkg::KIND_ECHO, slet_pkg::CH_TILDE, 1'b0, 1'b1));
        add_row(1'b1, slet_pkg::CH_BS,    1, 1'b0, 1'b0, '0);
        add_row(1'b1, 8'h1B,              1, 1'b1, 1'b0, '0);
        add_row(1'b1, slet_pkg::CH_CR,    1, 1'b0, 1'b0, '0);
        add_row(1'b1, 8'h5A, LINE_DEPTH + 1, 1'b0, 1'b0, '0);
        add_row(1'b1, slet_pkg::CH_LF,    1, 1'b0, 1'b0, '0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].echo != echo_on) begin
                set_echo(dir_rows[r].echo);
            end
            repeat (dir_rows[r].reps) begin
                send_byte(dir_rows[r].rx);
                edit_line(dir_rows[r].rx, !dir_rows[r].typed);
                if (dir_rows[r].typed && dir_rows[r].typed_has) begin
                    results_due.insert(results_due.size(), dir_rows[r].typed_item);
                end
            end
        end

        for (int phase = 0; phase < 4; phase++) begin
            set_echo((phase % 2) == 0);
            send_idle_pct  = (phase == 1) ? 68 : (phase == 3) ? 10 : 0;
            recv_stall_pct = (phase == 2) ? 68 : (phase == 3) ? 10 : 0;
            if (phase == 0) begin
                // Hold the result side off while bytes keep coming so the block backs up.
                hold_toggle <= ~hold_toggle;
            end
            line_bytes = 0;
            while (line_bytes < PHASE_ITEMS) begin
                if ($urandom_range(99) < 15) begin
                    feed_byte(8'($urandom_range(255)));
                    line_bytes += 1;
                end else begin
                    line_len = ($urandom_range(7) == 0) ? $urandom_range(40, 28)
                                                        : $urandom_range(12);
                    for (int k = 0; k < line_len; k++) begin
                        pick = $urandom_range(99);
                        if (pick < 18) begin
                            b = slet_pkg::CH_SPACE;
                        end else if (pick < 26) begin
                            b = $urandom_range(1) ? slet_pkg::CH_BS : slet_pkg::CH_DEL;
                        end else begin
                            b = 8'($urandom_range(8'h7E, 8'h21));
                        end
                        feed_byte(b);
                    end
                    feed_byte($urandom_range(1) ? slet_pkg::CH_CR : slet_pkg::CH_LF);
                    line_bytes += line_len + 1;
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: shell_line_editor_tokenizer.f
hw/rtl/slet_pkg.sv
hw/rtl/slet_ram.sv
hw/rtl/slet_dpath.sv
hw/rtl/slet_ctrl.sv
hw/rtl/shell_line_editor_tokenizer.sv
tb/tb.sv
